FILE: design/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg: shared types and constants for the date/time stepper
// Request/state structs, codes, reset values and calendar helper functions.
// ----------------------------------------------------------------------------
package dts_pkg;

	// request kinds
	localparam logic [1:0] KIND_STEP   = 2'd0;
	localparam logic [1:0] KIND_LOAD   = 2'd1;
	localparam logic [1:0] KIND_COMMIT = 2'd2;

	// step field selectors
	localparam logic [2:0] FIELD_YEAR   = 3'd0;
	localparam logic [2:0] FIELD_MONTH  = 3'd1;
	localparam logic [2:0] FIELD_DAY    = 3'd2;
	localparam logic [2:0] FIELD_HOUR   = 3'd3;
	localparam logic [2:0] FIELD_MINUTE = 3'd4;

	// config register indexes
	localparam logic [1:0] REG_MIN_YEAR     = 2'd0;
	localparam logic [1:0] REG_MAX_YEAR     = 2'd1;
	localparam logic [1:0] REG_DEFAULT_YEAR = 2'd2;

	localparam int YEAR_W = 14;
	localparam int CENT_W = 8;
	localparam int REM_W  = 7;

	localparam logic [YEAR_W-1:0] RST_MIN_YEAR     = 14'd2020;
	localparam logic [YEAR_W-1:0] RST_MAX_YEAR     = 14'd2099;
	localparam logic [YEAR_W-1:0] RST_DEFAULT_YEAR = 14'd2026;

	localparam logic [REM_W-1:0]  REM_MAX   = 7'd99;
	localparam logic [CENT_W-1:0] CENT_BIAS = 8'd4;   // 400 years, keeps the weekday
	localparam logic [4:0]        HOUR_MAX  = 5'd23;
	localparam logic [5:0]        MIN_MAX   = 6'd59;
	localparam logic [3:0]        MONTH_MAX = 4'd12;

	// reciprocal of 100, exact for 15-bit dividends: q = (x * 5243) >> 19
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int          RECIP_SH  = 19;

	// year kept together with its century and year-in-century
	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [CENT_W-1:0] cent;
		logic [REM_W-1:0]  rem;
	} year_split_t;

	typedef struct packed {
		year_split_t min_y;
		year_split_t max_y;
		year_split_t def_y;
	} cfg_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [CENT_W-1:0] cent;
		logic [REM_W-1:0]  rem;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [4:0]        hour;
		logic [5:0]        minute;
	} date_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [2:0]        field;
		logic              down;
		logic              read_ok;
		logic [15:0]       load_year;
		logic [CENT_W-1:0] load_cent;
		logic [REM_W-1:0]  load_rem;
		logic [7:0]        load_month;
		logic [7:0]        load_day;
		logic [7:0]        load_hour;
		logic [7:0]        load_minute;
	} req_t;

	function automatic year_split_t split_year(input logic [YEAR_W-1:0] y);
		logic [YEAR_W+12:0] prod;
		logic [CENT_W-1:0]  q;
		logic [YEAR_W-1:0]  diff;
		year_split_t        res;
		prod = y * RECIP_100;
		q = prod[YEAR_W+12:RECIP_SH];
		diff = y - {{(YEAR_W-CENT_W){1'b0}}, q} * 14'd100;
		res.year = y;
		res.cent = q;
		res.rem = diff[REM_W-1:0];
		return res;
	endfunction

	// y % 4 equals rem % 4 since 100 is a multiple of 4
	function automatic logic is_leap(input logic [CENT_W-1:0] cent,
			input logic [REM_W-1:0] rem);
		if (rem == '0) begin
			return cent[1:0] == 2'd0;
		end
		return rem[1:0] == 2'd0;
	endfunction

	function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
		logic [4:0] d;
		unique case (m)
			4'd2: d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default: d = 5'd31;
		endcase
		return d;
	endfunction

	function automatic logic [2:0] month_offset(input logic [3:0] m);
		logic [2:0] o;
		unique case (m)
			4'd2: o = 3'd3;
			4'd3: o = 3'd2;
			4'd4: o = 3'd5;
			4'd6: o = 3'd3;
			4'd7: o = 3'd5;
			4'd8: o = 3'd1;
			4'd9: o = 3'd4;
			4'd10: o = 3'd6;
			4'd11: o = 3'd2;
			4'd12: o = 3'd4;
			default: o = 3'd0;
		endcase
		return o;
	endfunction

endpackage

FILE: design/dts_next.sv
// ----------------------------------------------------------------------------
// dts_next: next-state logic of the date/time stepper
// Applies one step, load or commit request to the current date and time.
// ----------------------------------------------------------------------------
module dts_next (
	input  dts_pkg::date_t cur,
	input  dts_pkg::cfg_t  cfg,
	input  dts_pkg::req_t  req,
	output dts_pkg::date_t nxt,
	output logic           write_clock
);

	// wrap a small field by one within lo..hi
	function automatic logic [5:0] wrap6(input logic [5:0] v, input logic dn,
			input logic [5:0] lo, input logic [5:0] hi);
		logic [6:0] x;
		logic       neg;
		logic       gt;
		neg = dn && (v == 6'd0);
		x = dn ? ({1'b0, v} - 7'd1) : ({1'b0, v} + 7'd1);
		gt = !neg && (x > {1'b0, hi});
		if (gt) begin
			return lo;
		end else if (neg || (x < {1'b0, lo})) begin
			return hi;
		end
		return x[5:0];
	endfunction

	logic                      cur_leap;
	logic [dts_pkg::YEAR_W:0]  yx;
	logic                      yneg, ygt, ylt;
	dts_pkg::year_split_t      ystep;
	logic [4:0]                md;
	logic [4:0]                md_load;
	logic                      good;
	logic [5:0]                w;

	always_comb begin
		cur_leap = dts_pkg::is_leap(cur.cent, cur.rem);

		// year plus or minus one, then wrap to the configured range
		yneg = req.down && (cur.year == '0);
		yx = req.down ? ({1'b0, cur.year} - 15'd1) : ({1'b0, cur.year} + 15'd1);
		ygt = !yneg && (yx > {1'b0, cfg.max_y.year});
		ylt = !ygt && (yneg || (yx < {1'b0, cfg.min_y.year}));
		ystep.year = yx[dts_pkg::YEAR_W-1:0];
		if (req.down) begin
			if (cur.rem == '0) begin
				ystep.rem = dts_pkg::REM_MAX;
				ystep.cent = cur.cent - 8'd1;
			end else begin
				ystep.rem = cur.rem - 7'd1;
				ystep.cent = cur.cent;
			end
		end else begin
			if (cur.rem == dts_pkg::REM_MAX) begin
				ystep.rem = '0;
				ystep.cent = cur.cent + 8'd1;
			end else begin
				ystep.rem = cur.rem + 7'd1;
				ystep.cent = cur.cent;
			end
		end
		if (ygt) begin
			ystep = cfg.min_y;
		end else if (ylt) begin
			ystep = cfg.max_y;
		end

		md_load = dts_pkg::month_days(dts_pkg::is_leap(req.load_cent, req.load_rem),
			req.load_month[3:0]);
		good = req.read_ok
			&& (req.load_year >= {2'b00, cfg.min_y.year})
			&& (req.load_year <= {2'b00, cfg.max_y.year})
			&& (req.load_month >= 8'd1) && (req.load_month <= {4'd0, dts_pkg::MONTH_MAX})
			&& (req.load_day >= 8'd1) && (req.load_day <= {3'd0, md_load})
			&& (req.load_hour <= {3'd0, dts_pkg::HOUR_MAX})
			&& (req.load_minute <= {2'd0, dts_pkg::MIN_MAX});

		nxt = cur;
		md = '0;
		w = '0;
		write_clock = 1'b0;
		unique case (req.kind)
			dts_pkg::KIND_STEP: begin
				unique case (req.field)
					dts_pkg::FIELD_YEAR: begin
						nxt.year = ystep.year;
						nxt.cent = ystep.cent;
						nxt.rem = ystep.rem;
						md = dts_pkg::month_days(dts_pkg::is_leap(ystep.cent, ystep.rem),
							cur.month);
						if (cur.day > md) begin
							nxt.day = md;
						end
					end
					dts_pkg::FIELD_MONTH: begin
						w = wrap6({2'b00, cur.month}, req.down, 6'd1,
							{2'b00, dts_pkg::MONTH_MAX});
						nxt.month = w[3:0];
						md = dts_pkg::month_days(cur_leap, w[3:0]);
						if (cur.day > md) begin
							nxt.day = md;
						end
					end
					dts_pkg::FIELD_DAY: begin
						md = dts_pkg::month_days(cur_leap, cur.month);
						w = wrap6({1'b0, cur.day}, req.down, 6'd1, {1'b0, md});
						nxt.day = w[4:0];
					end
					dts_pkg::FIELD_HOUR: begin
						w = wrap6({1'b0, cur.hour}, req.down, 6'd0,
							{1'b0, dts_pkg::HOUR_MAX});
						nxt.hour = w[4:0];
					end
					dts_pkg::FIELD_MINUTE: begin
						w = wrap6(cur.minute, req.down, 6'd0, dts_pkg::MIN_MAX);
						nxt.minute = w;
					end
					default: begin
					end
				endcase
			end
			dts_pkg::KIND_LOAD: begin
				if (good) begin
					nxt.year = req.load_year[dts_pkg::YEAR_W-1:0];
					nxt.cent = req.load_cent;
					nxt.rem = req.load_rem;
					nxt.month = req.load_month[3:0];
					nxt.day = req.load_day[4:0];
					nxt.hour = req.load_hour[4:0];
					nxt.minute = req.load_minute[5:0];
				end else begin
					nxt.year = cfg.def_y.year;
					nxt.cent = cfg.def_y.cent;
					nxt.rem = cfg.def_y.rem;
					nxt.month = 4'd1;
					nxt.day = 5'd1;
					nxt.hour = '0;
					nxt.minute = '0;
				end
			end
			dts_pkg::KIND_COMMIT: begin
				write_clock = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: design/dts_weekday.sv
// ----------------------------------------------------------------------------
// dts_weekday: day of week of a date, 0 = Sunday
// Sakamoto's rule worked on century and year-in-century, reduced mod 7.
// ----------------------------------------------------------------------------
module dts_weekday (
	input  dts_pkg::date_t date,
	output logic [2:0]     weekday
);

	logic [dts_pkg::CENT_W-1:0] h;
	logic [dts_pkg::REM_W-1:0]  r;
	logic [10:0]                s;
	logic [4:0]                 f1;
	logic [3:0]                 f2;

	always_comb begin
		// year + 400, minus one for January and February
		h = date.cent + dts_pkg::CENT_BIAS;
		r = date.rem;
		if (date.month < 4'd3) begin
			if (date.rem == '0) begin
				r = dts_pkg::REM_MAX;
				h = h - 8'd1;
			end else begin
				r = date.rem - 7'd1;
			end
		end
		// 100h + r + 25h + r/4 - h + h/4 + off + d, with 124 = 5 mod 7
		s = ({3'b000, h} << 2) + {3'b000, h} + {4'd0, r} + {6'd0, r[6:2]}
			+ {5'd0, h[7:2]} + {8'd0, dts_pkg::month_offset(date.month)}
			+ {6'd0, date.day};
		// 8 = 1 mod 7: fold octal digits
		f1 = {2'b00, s[2:0]} + {2'b00, s[5:3]} + {2'b00, s[8:6]} + {3'b000, s[10:9]};
		f2 = {1'b0, f1[2:0]} + {2'b00, f1[4:3]};
		if (f2 >= 4'd7) begin
			weekday = 3'(f2 - 4'd7);
		end else begin
			weekday = f2[2:0];
		end
	end

endmodule

FILE: design/date_time_stepper.sv
// ----------------------------------------------------------------------------
// date_time_stepper: editable date and time of day with weekday
// Step, load and commit requests on a settable year/month/day/hour/minute.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while in_stall is low, and each request
// yields one result after an input register, the state update (which also
// snapshots the result), and the output register that adds the weekday. The
// state update reads the state it writes, so a step that depends on the previous
// one follows it directly. The stall on the input rises only when the output
// is stalled and both internal stages are full. The user must write min_year,
// max_year and default_year only while no request is in flight; the block does
// not enforce this. A write takes effect at the same edge. The year is kept
// alongside its century and year-in-century, so leap years and weekday need
// no divide in the loop; splitting a loaded or configured year costs two
// constant multiplies in front of its register.
module date_time_stepper (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [2:0]  field,
	input  logic        down,
	input  logic        read_ok,
	input  logic [15:0] load_year,
	input  logic [7:0]  load_month,
	input  logic [7:0]  load_day,
	input  logic [7:0]  load_hour,
	input  logic [7:0]  load_minute,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [13:0] cur_year,
	output logic [3:0]  cur_month,
	output logic [4:0]  cur_day,
	output logic [4:0]  cur_hour,
	output logic [5:0]  cur_minute,
	output logic [2:0]  weekday,
	output logic        write_clock,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	// reset year, already split
	localparam dts_pkg::year_split_t RST_YEAR_SPLIT =
		dts_pkg::split_year(dts_pkg::RST_DEFAULT_YEAR);

	// config: each year stored already split
	dts_pkg::cfg_t        cfg_q;
	dts_pkg::year_split_t cfg_split;

	// pipeline
	logic                 s0_valid_q;
	dts_pkg::req_t        req_s0;
	logic                 s1_valid_q;
	dts_pkg::date_t       date_s1;
	logic                 wr_s1;

	dts_pkg::date_t       state_q;
	dts_pkg::date_t       state_nxt;
	logic                 wr_nxt;
	logic [2:0]           wd;

	logic                 out_ready;
	logic                 s1_ready;
	logic                 in_take;
	logic                 s0_move;
	dts_pkg::year_split_t load_split;

	assign out_ready = !out_valid || !out_stall;
	assign s1_ready  = !s1_valid_q || out_ready;
	assign s0_move   = s0_valid_q && s1_ready;
	assign in_stall  = s0_valid_q && !s1_ready;
	assign in_take   = in_valid && !in_stall;

	assign cfg_split  = dts_pkg::split_year(cfg_data);
	assign load_split = dts_pkg::split_year(load_year[13:0]);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_y <= dts_pkg::split_year(dts_pkg::RST_MIN_YEAR);
			cfg_q.max_y <= dts_pkg::split_year(dts_pkg::RST_MAX_YEAR);
			cfg_q.def_y <= dts_pkg::split_year(dts_pkg::RST_DEFAULT_YEAR);
		end else if (cfg_we) begin
			unique case (cfg_index)
				dts_pkg::REG_MIN_YEAR:     cfg_q.min_y <= cfg_split;
				dts_pkg::REG_MAX_YEAR:     cfg_q.max_y <= cfg_split;
				dts_pkg::REG_DEFAULT_YEAR: cfg_q.def_y <= cfg_split;
				default: begin
				end
			endcase
		end
	end

	// input register: raw request plus the split load year
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_valid_q <= 1'b0;
		end else if (in_take) begin
			s0_valid_q <= 1'b1;
		end else if (s0_move) begin
			s0_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s0.kind        <= kind;
			req_s0.field       <= field;
			req_s0.down        <= down;
			req_s0.read_ok     <= read_ok;
			req_s0.load_year   <= load_year;
			req_s0.load_cent   <= load_split.cent;
			req_s0.load_rem    <= load_split.rem;
			req_s0.load_month  <= load_month;
			req_s0.load_day    <= load_day;
			req_s0.load_hour   <= load_hour;
			req_s0.load_minute <= load_minute;
		end
	end

	dts_next u_next (
		.cur         (state_q),
		.cfg         (cfg_q),
		.req         (req_s0),
		.nxt         (state_nxt),
		.write_clock (wr_nxt)
	);

	// date/time state, updated as each request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.year   <= dts_pkg::RST_DEFAULT_YEAR;
			state_q.cent   <= RST_YEAR_SPLIT.cent;
			state_q.rem    <= RST_YEAR_SPLIT.rem;
			state_q.month  <= 4'd1;
			state_q.day    <= 5'd1;
			state_q.hour   <= '0;
			state_q.minute <= '0;
		end else if (s0_move) begin
			state_q <= state_nxt;
		end
	end

	// result snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_ready) begin
			s1_valid_q <= s0_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s0_move) begin
			date_s1 <= state_nxt;
			wr_s1   <= wr_nxt;
		end
	end

	dts_weekday u_weekday (
		.date    (date_s1),
		.weekday (wd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && s1_valid_q) begin
			cur_year    <= date_s1.year;
			cur_month   <= date_s1.month;
			cur_day     <= date_s1.day;
			cur_hour    <= date_s1.hour;
			cur_minute  <= date_s1.minute;
			weekday     <= wd;
			write_clock <= wr_s1;
		end
	end

	// split year must always agree with the year itself
	a_year_split: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.year == ({6'd0, state_q.cent} * 14'd100 + {7'd0, state_q.rem}))
		else $error("year and century/remainder disagree");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.month >= 4'd1) && (state_q.month <= dts_pkg::MONTH_MAX))
		else $error("month out of range");

	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.day >= 5'd1) && (state_q.day <= dts_pkg::month_days(
			dts_pkg::is_leap(state_q.cent, state_q.rem), state_q.month)))
		else $error("day beyond month length");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (weekday <= 3'd6))
		else $error("weekday out of range");

	// state only moves together with a request entering the snapshot stage
	a_state_move: assert property (@(posedge clk) disable iff (!arst_n)
		!s0_move |=> $stable(state_q))
		else $error("state changed without a request");

endmodule
